### rtl/kiss_frame_receiver_macros.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef KISS_FRAME_RECEIVER_MACROS_SVH
`define KISS_FRAME_RECEIVER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define KFR_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("frame receiver check failed");

// A condition that, once seen, implies another one in the same cycle.
`define KFR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// A condition that, once seen, implies another one in the next cycle.
`define KFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

### rtl/kfr_pkg.sv
// Types and constants of the frame receiver.
`default_nettype none

package kfr_pkg;

  localparam logic [7:0] FEND  = 8'hC0;
  localparam logic [7:0] FESC  = 8'hDB;
  localparam logic [7:0] TFEND = 8'hDC;
  localparam logic [7:0] TFESC = 8'hDD;

  localparam int unsigned LEN_WIDTH           = 16;
  localparam int unsigned STAT_WIDTH          = 32;
  localparam int unsigned COUNTER_WIDTH_DEF   = 32;
  localparam logic [LEN_WIDTH-1:0] MAX_LEN_RESET = 16'd1600;

  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_GOOD       = 2'd1,
    KIND_BAD_ESCAPE = 2'd2,
    KIND_TOO_LONG   = 2'd3
  } kind_t;

  // Outcome of one byte, passed from the decoder to the result register.
  typedef struct packed {
    logic                  emit;
    kind_t                 kind;
    logic [7:0]            data;
    logic [STAT_WIDTH-1:0] good;
    logic [STAT_WIDTH-1:0] errors;
  } dec_res_t;

endpackage

`default_nettype wire

### rtl/kfr_ifs.sv
// Handshake channel interfaces of the frame receiver.
`default_nettype none

interface kfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface kfr_result_if;
  import kfr_pkg::*;
  logic                  valid;
  logic                  ready;
  kind_t                 kind;
  logic [7:0]            data_byte;
  logic [STAT_WIDTH-1:0] good_frames;
  logic [STAT_WIDTH-1:0] error_frames;
  modport source (output valid, output kind, output data_byte, output good_frames,
                  output error_frames, input ready);
  modport sink (input valid, input kind, input data_byte, input good_frames,
                input error_frames, output ready);
endinterface

interface kfr_cfg_if;
  import kfr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [LEN_WIDTH-1:0] max_raw_length;
  modport source (output valid, output max_raw_length, input ready);
  modport sink (input valid, input max_raw_length, output ready);
endinterface

`default_nettype wire

### rtl/kfr_decode.sv
// Frame state and counters: decodes one raw byte per step.
`default_nettype none

module kfr_decode #(
  parameter int unsigned COUNTER_WIDTH = kfr_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           step,
  input  wire logic [7:0]                     rx_byte,
  input  wire logic [kfr_pkg::LEN_WIDTH-1:0]  max_len,
  output kfr_pkg::dec_res_t                   res
);
  import kfr_pkg::*;

  logic                     inside_frame, inside_frame_next;
  logic                     escape_pending, escape_pending_next;
  logic                     frame_bad, frame_bad_next;
  logic                     payload_seen, payload_seen_next;
  logic [LEN_WIDTH-1:0]     raw_count, raw_count_next;
  logic [COUNTER_WIDTH-1:0] good_count, good_count_next;
  logic [COUNTER_WIDTH-1:0] error_count, error_count_next;

  always_comb begin
    inside_frame_next   = inside_frame;
    escape_pending_next = escape_pending;
    frame_bad_next      = frame_bad;
    payload_seen_next   = payload_seen;
    raw_count_next      = raw_count;
    good_count_next     = good_count;
    error_count_next    = error_count;
    res.emit = 1'b0;
    res.kind = KIND_DATA;
    res.data = 8'h00;

    if (rx_byte == FEND) begin
      // A delimiter either closes a non-empty frame or opens a fresh one.
      if (inside_frame && (raw_count != '0)) begin
        if (frame_bad || escape_pending) begin
          error_count_next = error_count + 1'b1;
          res.emit = 1'b1;
          res.kind = KIND_BAD_ESCAPE;
        end else if (payload_seen) begin
          good_count_next = good_count + 1'b1;
          res.emit = 1'b1;
          res.kind = KIND_GOOD;
        end
        inside_frame_next = 1'b0;
      end else begin
        inside_frame_next = 1'b1;
      end
      escape_pending_next = 1'b0;
      frame_bad_next      = 1'b0;
      payload_seen_next   = 1'b0;
      raw_count_next      = '0;
    end else if (inside_frame) begin
      if (raw_count >= max_len) begin
        error_count_next    = error_count + 1'b1;
        res.emit            = 1'b1;
        res.kind            = KIND_TOO_LONG;
        inside_frame_next   = 1'b0;
        escape_pending_next = 1'b0;
        frame_bad_next      = 1'b0;
        payload_seen_next   = 1'b0;
        raw_count_next      = '0;
      end else begin
        raw_count_next = raw_count + 1'b1;
        // The command byte and anything after a bad escape are swallowed.
        if ((raw_count != '0) && !frame_bad) begin
          if (escape_pending) begin
            escape_pending_next = 1'b0;
            if (rx_byte == TFEND) begin
              payload_seen_next = 1'b1;
              res.emit = 1'b1;
              res.data = FEND;
            end else if (rx_byte == TFESC) begin
              payload_seen_next = 1'b1;
              res.emit = 1'b1;
              res.data = FESC;
            end else begin
              frame_bad_next = 1'b1;
            end
          end else if (rx_byte == FESC) begin
            escape_pending_next = 1'b1;
          end else begin
            payload_seen_next = 1'b1;
            res.emit = 1'b1;
            res.data = rx_byte;
          end
        end
      end
    end

    res.good   = STAT_WIDTH'(good_count_next);
    res.errors = STAT_WIDTH'(error_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame   <= 1'b0;
      escape_pending <= 1'b0;
      frame_bad      <= 1'b0;
      payload_seen   <= 1'b0;
      raw_count      <= '0;
      good_count     <= '0;
      error_count    <= '0;
    end else if (step) begin
      inside_frame   <= inside_frame_next;
      escape_pending <= escape_pending_next;
      frame_bad      <= frame_bad_next;
      payload_seen   <= payload_seen_next;
      raw_count      <= raw_count_next;
      good_count     <= good_count_next;
      error_count    <= error_count_next;
    end
  end

`include "kiss_frame_receiver_macros.svh"

  `KFR_ASSERT_IMPLY(a_good_counts_one, res.emit && (res.kind == KIND_GOOD), res.good == STAT_WIDTH'(good_count + 1'b1))
  `KFR_ASSERT_IMPLY(a_data_needs_frame, res.emit && (res.kind == KIND_DATA), inside_frame && (raw_count != '0) && !frame_bad)
  `KFR_ASSERT_NEXT(a_hold_without_step, !step, $stable(raw_count) && $stable(good_count) && $stable(error_count))
  `KFR_ASSERT(a_count_in_limit, !inside_frame || (raw_count <= max_len) || (raw_count == '0) || !step)

endmodule

`default_nettype wire

### rtl/kiss_frame_receiver.sv
// Top level of the frame receiver: input register, decoder and result register.
//
//  Channel  Role    Handshake      Moves
//  rx       sink    valid/ready    one raw byte from the serial line
//  res      source  valid/ready    one payload byte or one end-of-frame word
//  cfg      sink    valid/ready    new maximum raw frame length
//
// One word is taken on every cycle when the result side keeps up; a result
// reaches the port once its byte, after being accepted, has passed the input
// register and the result register.
// The decoder state and counters are updated with no wait state, so the input
// register advances whenever the result register is empty or being emptied.
// Synchronous reset clears all flags and counters and restores the limit to 1600.
// A stall on res backs up through the result register into the input register.
`default_nettype none

module kiss_frame_receiver #(
  parameter int unsigned COUNTER_WIDTH = kfr_pkg::COUNTER_WIDTH_DEF
) (
  input wire logic     clk,
  input wire logic     rst,
  kfr_byte_if.sink     rx,
  kfr_result_if.source res,
  kfr_cfg_if.sink      cfg
);
  import kfr_pkg::*;

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;

  // Result register.
  logic                  out_valid;
  kind_t                 out_kind;
  logic [7:0]            out_data;
  logic [STAT_WIDTH-1:0] out_good;
  logic [STAT_WIDTH-1:0] out_errors;

  logic [LEN_WIDTH-1:0] max_raw_length;

  dec_res_t dec;
  logic     advance;

  // The held byte is decoded when the result register can take its outcome.
  assign advance  = in_valid && (!out_valid || res.ready);
  assign rx.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  kfr_decode #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .max_len (max_raw_length),
    .res     (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || res.ready) begin
      out_valid <= advance && dec.emit;
    end
    if (advance && dec.emit) begin
      out_kind   <= dec.kind;
      out_data   <= dec.data;
      out_good   <= dec.good;
      out_errors <= dec.errors;
    end
  end

  // The user must change the limit only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_raw_length <= MAX_LEN_RESET;
    end else if (cfg.valid) begin
      max_raw_length <= cfg.max_raw_length;
    end
  end

  assign res.valid        = out_valid;
  assign res.kind         = out_kind;
  assign res.data_byte    = out_data;
  assign res.good_frames  = out_good;
  assign res.error_frames = out_errors;

`include "kiss_frame_receiver_macros.svh"

  `KFR_ASSERT_NEXT(a_in_reg_holds, in_valid && !advance, in_valid && $stable(in_byte))
  `KFR_ASSERT_IMPLY(a_end_word_zero_data, out_valid && (out_kind != KIND_DATA), out_data == 8'h00)
  `KFR_ASSERT_NEXT(a_out_reg_holds, out_valid && !res.ready, out_valid && $stable(out_data))

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench of the frame receiver: framing, escapes, length limit and counters.
module tb;
  import kfr_pkg::*;

  // Cycles with no word moving on any channel before the run is declared hung.
  // The slowest correct stretch is a sender gap, a result stall and the drain
  // pause below, which stay well under this limit.
  localparam int WATCHDOG_LIMIT = 1000;
  // A word reaches the result port through the input register and the result
  // register; a byte that yields nothing may still sit in the input register.
  localparam int DRAIN_CYCLES = 4;

  // One word on the result channel, as the decoder should produce it.
  typedef struct packed {
    kind_t                 kind;
    logic [7:0]            data;
    logic [STAT_WIDTH-1:0] good;
    logic [STAT_WIDTH-1:0] errors;
  } rx_word_t;

  logic clk = 1'b0;
  logic rst;

  kfr_byte_if   byte_ch ();
  kfr_result_if result_ch ();
  kfr_cfg_if    limit_ch ();

  kiss_frame_receiver dut (
    .clk (clk),
    .rst (rst),
    .rx  (byte_ch),
    .res (result_ch),
    .cfg (limit_ch)
  );

  always #5 clk = ~clk;

  // Decoder state as the testbench believes it to be.
  logic                         frame_open;
  logic                         esc_pending;
  logic                         frame_bad;
  logic                         payload_seen;
  logic [LEN_WIDTH-1:0]         raw_len;
  logic [LEN_WIDTH-1:0]         max_len;
  logic [COUNTER_WIDTH_DEF-1:0] good_total;
  logic [COUNTER_WIDTH_DEF-1:0] error_total;

  // Decoded words still owed by the block, oldest first.
  rx_word_t pending_words[$];

  int  mismatches    = 0;
  int  bytes_sent    = 0;
  int  quiet_cycles  = 0;
  // Random idling on both the byte and the result side; switched off for the
  // last part of the run so that the block also sees a full-rate stream.
  bit  bursts_on     = 1'b1;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void push_word(input kind_t kind, input logic [7:0] data);
    rx_word_t w;
    w.kind   = kind;
    w.data   = data;
    w.good   = good_total[STAT_WIDTH-1:0];
    w.errors = error_total[STAT_WIDTH-1:0];
    pending_words = {pending_words, w};
  endfunction

  function automatic void clear_frame();
    esc_pending  = 1'b0;
    frame_bad    = 1'b0;
    payload_seen = 1'b0;
    raw_len      = '0;
  endfunction

  // Advances the decoder by one raw byte and queues any word that it yields.
  function automatic void decode_byte(input logic [7:0] b);
    if (b == FEND) begin
      // A delimiter closes a frame that has taken raw bytes; a delimiter outside
      // a frame, or straight after an opening one, just opens an empty frame.
      if (frame_open && raw_len != 0) begin
        if (frame_bad || esc_pending) begin
          error_total = error_total + 1'b1;
          push_word(KIND_BAD_ESCAPE, 8'h00);
        end else if (payload_seen) begin
          good_total = good_total + 1'b1;
          push_word(KIND_GOOD, 8'h00);
        end
        frame_open = 1'b0;
      end else begin
        frame_open = 1'b1;
      end
      clear_frame();
    end else if (frame_open) begin
      if (raw_len >= max_len) begin
        // The frame is aborted even if it is already marked bad.
        error_total = error_total + 1'b1;
        push_word(KIND_TOO_LONG, 8'h00);
        frame_open = 1'b0;
        clear_frame();
      end else begin
        raw_len = raw_len + 1'b1;
        // The command byte is only counted, and a bad frame emits nothing more.
        if (raw_len != 1 && !frame_bad) begin
          if (esc_pending) begin
            esc_pending = 1'b0;
            if (b == TFEND) begin
              payload_seen = 1'b1;
              push_word(KIND_DATA, FEND);
            end else if (b == TFESC) begin
              payload_seen = 1'b1;
              push_word(KIND_DATA, FESC);
            end else begin
              frame_bad = 1'b1;
            end
          end else if (b == FESC) begin
            esc_pending = 1'b1;
          end else begin
            payload_seen = 1'b1;
            push_word(KIND_DATA, b);
          end
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  // Every word taken from the result port is compared with the oldest one owed.
  always @(posedge clk) begin : result_check
    rx_word_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_words.size() == 0) begin
        note_mismatch("unexpected word, kind", '0, result_ch.kind);
      end else begin
        want = pending_words.pop_front();
        if (result_ch.kind !== want.kind)
          note_mismatch("kind", want.kind, result_ch.kind);
        if (result_ch.data_byte !== want.data)
          note_mismatch("data_byte", want.data, result_ch.data_byte);
        if (result_ch.good_frames !== want.good)
          note_mismatch("good_frames", want.good, result_ch.good_frames);
        if (result_ch.error_frames !== want.errors)
          note_mismatch("error_frames", want.errors, result_ch.error_frames);
      end
    end
  end

  // The run is declared hung when no word moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)
        || (limit_ch.valid && limit_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: ready drops in random bursts.
  // ---------------------------------------------------------------------------

  initial begin : result_stalls
    int hold;
    hold = 0;
    result_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (bursts_on && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(0, 3);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte side
  // ---------------------------------------------------------------------------

  // Offers one raw byte, possibly after a short gap, and returns at the edge at
  // which it is accepted. Valid is left high so that bytes can follow back to back.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
  endtask

  // Stops the byte stream and waits until the block has nothing left to say.
  task automatic wait_until_quiet();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The limit is only changed while the block is idle.
  task automatic write_limit(input logic [LEN_WIDTH-1:0] value);
    wait_until_quiet();
    limit_ch.valid          <= 1'b1;
    limit_ch.max_raw_length <= value;
    @(posedge clk);
    while (!limit_ch.ready) @(posedge clk);
    limit_ch.valid <= 1'b0;
    max_len = value;
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Random byte that lands on one of the framing codes fairly often.
  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 15))
      0:       return FEND;
      1:       return FESC;
      2:       return TFEND;
      3:       return TFESC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed frames with random payload, escaped as a sender would,
  // with now and then noise between frames, a broken escape or a dangling FESC.
  task automatic send_random_frame();
    int         len;
    int         noise;
    logic [7:0] b;
    if ($urandom_range(0, 9) == 0) begin
      noise = $urandom_range(1, 4);
      repeat (noise) send_byte(random_byte());
    end
    send_byte(FEND);
    if ($urandom_range(0, 7) == 0)
      send_byte(FEND);
    send_byte(random_byte());
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    repeat (len) begin
      b = random_byte();
      if ($urandom_range(0, 24) == 0) begin
        send_byte(FESC);
        do b = random_byte(); while (b == TFEND || b == TFESC);
        send_byte(b);
      end else if (b == FEND) begin
        send_byte(FESC);
        send_byte(TFEND);
      end else if (b == FESC) begin
        send_byte(FESC);
        send_byte(TFESC);
      end else begin
        send_byte(b);
      end
    end
    if ($urandom_range(0, 19) == 0)
      send_byte(FESC);
    send_byte(FEND);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Framing and escapes under the reset limit: stray bytes, a doubled opening
  // delimiter, a command byte equal to FESC, both escape pairs, an empty frame,
  // a broken escape and a FESC left just before the closing delimiter.
  task automatic test_framing();
    send_bytes('{8'h00, 8'hFF});
    send_bytes('{FEND, FEND, FESC, 8'h00, 8'hFF, FESC, TFEND, FESC, TFESC, FEND});
    send_bytes('{8'h55});
    send_bytes('{FEND, 8'h00, FEND});
    send_bytes('{FEND, 8'h00, FESC, 8'h41, 8'h42, FEND});
    send_bytes('{FEND, 8'h00, 8'h11, FESC, FEND});
  endtask

  // Length limit at its smallest settings: an abort on a clean frame, an abort
  // on a frame already marked bad, a limit of zero, and a limit of one.
  task automatic test_length_limit();
    write_limit(16'd2);
    send_bytes('{FEND, 8'h00, 8'h01, 8'h02, 8'h03});
    write_limit(16'd3);
    send_bytes('{FEND, 8'h00, FESC, 8'h41, 8'h42});
    write_limit(16'd0);
    send_bytes('{FEND, 8'h00, 8'h55});
    write_limit(16'd1);
    send_bytes('{FEND, 8'h00, FEND, FEND, 8'h07, 8'h08});
  endtask

  task automatic test_random_traffic(input int count, input logic [LEN_WIDTH-1:0] limit);
    int target;
    write_limit(limit);
    target = bytes_sent + count;
    while (bytes_sent < target) send_random_frame();
  endtask

  // The sender holds off after each frame until every owed word has come back.
  task automatic test_drain_pause();
    repeat (4) begin
      send_random_frame();
      wait_until_quiet();
    end
  endtask

  initial begin
    rst                     <= 1'b1;
    byte_ch.valid           <= 1'b0;
    byte_ch.rx_byte         <= 8'h00;
    limit_ch.valid          <= 1'b0;
    limit_ch.max_raw_length <= MAX_LEN_RESET;
    frame_open  = 1'b0;
    good_total  = '0;
    error_total = '0;
    max_len     = MAX_LEN_RESET;
    clear_frame();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_framing();
    test_length_limit();
    test_random_traffic(200, 16'hFFFF);
    test_random_traffic(200, 16'd12);
    test_drain_pause();
    test_random_traffic(80, 16'd1);
    bursts_on = 1'b0;
    test_random_traffic(200, MAX_LEN_RESET);

    wait_until_quiet();
    if (mismatches == 0 && pending_words.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
